>>> rtl/ppmds_pkg.sv
package ppmds_pkg;

  localparam int CHANNELS = 8;
  localparam int HIST_DEPTH = 4;
  localparam int HIST_ENTRIES = CHANNELS * HIST_DEPTH;

  localparam logic [15:0] SYNC_GAP_RESET = 16'd3000;
  localparam logic [15:0] PULSE_MIN_RESET = 16'd900;
  localparam logic [15:0] PULSE_MAX_RESET = 16'd2200;
  localparam logic [15:0] PULSE_RESET = 16'd1502;
  localparam logic [16:0] DEADBAND = 17'd3;
  localparam logic [15:0] CORRECTION = 16'd2;
  localparam logic [17:0] ROUNDING = 18'd2;

  localparam logic [2:0] LAST_CHANNEL = 3'(CHANNELS - 1);
  localparam logic [3:0] FRAME_FULL = 4'(CHANNELS);

  localparam logic [1:0] REG_SYNC_GAP = 2'd0;
  localparam logic [1:0] REG_PULSE_MIN = 2'd1;
  localparam logic [1:0] REG_PULSE_MAX = 2'd2;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_UPDATE
  } state_t;

endpackage

>>> rtl/ppmds_in_if.sv
interface ppmds_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] now_us;

  modport source (output valid, output op, output now_us, input ready);
  modport sink (input valid, input op, input now_us, output ready);
endinterface

>>> rtl/ppmds_out_if.sv
interface ppmds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel;
  logic [15:0] smoothed_us;
  logic        last;

  modport source (output valid, output channel, output smoothed_us, output last, input ready);
  modport sink (input valid, input channel, input smoothed_us, input last, output ready);
endinterface

>>> rtl/ppm_decode_and_smooth_unit.sv
// Channel   Dir  Payload                         Notes
// in_ch     in   op, now_us                      edge event or compute tick
// out_ch    out  channel, smoothed_us, last      one transfer per channel per tick
// cfg       in   cfg_we, cfg_index, cfg_data     sync_gap, pulse_min, pulse_max
//
// An edge event is handled without leaving idle. A compute tick runs, for each channel, four
// reads through the single read port of the history memory, a sum step and an update step.
// Reset clears control state, smoothed values and the history valid bits and loads the pulse
// table with PULSE_RESET, all at once; no clearing pass. The output register holds a result
// while out_ch stalls; the update step waits on it, and the next item is taken once a
// tick ends.
module ppm_decode_and_smooth_unit (
  input  logic        clk,
  input  logic        rst,
  ppmds_in_if.sink    in_ch,
  ppmds_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ppmds_pkg::state_t state;
  ppmds_pkg::state_t state_next;

  logic [15:0] sync_gap;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;

  logic [15:0] last_edge;
  logic [3:0]  frame_ch;
  logic [1:0]  hist_slot;
  logic [15:0] pulse_store [ppmds_pkg::CHANNELS];
  logic [15:0] smoothed [ppmds_pkg::CHANNELS];

  logic [15:0] hist_mem [ppmds_pkg::HIST_ENTRIES];
  logic        hist_valid [ppmds_pkg::HIST_ENTRIES];
  logic [15:0] rd_data;
  logic        rd_valid;
  logic        rd_use_pulse;

  logic [2:0]  ch_idx;
  logic [1:0]  step;
  logic [17:0] acc;

  logic        out_valid;
  logic [2:0]  out_channel;
  logic [15:0] out_smoothed;
  logic        out_last;

  logic        in_ready;
  logic        in_fire;
  logic        read_issue;
  logic        acc_clear;
  logic        acc_add;
  logic        upd_fire;

  logic [4:0]  rd_addr;
  logic [15:0] cur_pulse;
  logic [15:0] term;
  logic [15:0] gap;
  logic        in_window;
  logic [17:0] rounded;
  logic [15:0] mean;
  logic [16:0] mean_ext;
  logic [16:0] sm_ext;
  logic [15:0] smoothed_next;

  assign rd_addr = {ch_idx, step};
  assign cur_pulse = pulse_store[ch_idx];
  assign term = rd_use_pulse ? cur_pulse : (rd_valid ? rd_data : 16'd0);
  assign gap = in_ch.now_us - last_edge;
  assign in_window = (gap > pulse_min) && (gap < pulse_max);
  assign rounded = acc + ppmds_pkg::ROUNDING;
  assign mean = rounded[17:2];
  assign mean_ext = {1'b0, mean};
  assign sm_ext = {1'b0, smoothed[ch_idx]};

  always_comb begin
    smoothed_next = smoothed[ch_idx];
    if ((mean_ext + ppmds_pkg::DEADBAND) < sm_ext) begin
      smoothed_next = mean + ppmds_pkg::CORRECTION;
    end else if (mean_ext > (sm_ext + ppmds_pkg::DEADBAND)) begin
      smoothed_next = mean - ppmds_pkg::CORRECTION;
    end
  end

  always_comb begin
    in_ready = 1'b0;
    read_issue = 1'b0;
    acc_clear = 1'b0;
    acc_add = 1'b0;
    upd_fire = 1'b0;
    unique case (state)
      ppmds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ppmds_pkg::ST_READ: begin
        read_issue = 1'b1;
        acc_clear = (step == 2'd0);
        acc_add = (step != 2'd0);
      end
      ppmds_pkg::ST_SUM: begin
        acc_add = 1'b1;
      end
      ppmds_pkg::ST_UPDATE: begin
        upd_fire = !out_valid || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_fire = in_ch.valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ppmds_pkg::ST_IDLE: begin
        if (in_fire && in_ch.op == ppmds_pkg::OP_TICK) begin
          state_next = ppmds_pkg::ST_READ;
        end
      end
      ppmds_pkg::ST_READ: begin
        if (step == 2'd3) begin
          state_next = ppmds_pkg::ST_SUM;
        end
      end
      ppmds_pkg::ST_SUM: begin
        state_next = ppmds_pkg::ST_UPDATE;
      end
      ppmds_pkg::ST_UPDATE: begin
        if (upd_fire) begin
          state_next = (ch_idx == ppmds_pkg::LAST_CHANNEL) ? ppmds_pkg::ST_IDLE
                                                           : ppmds_pkg::ST_READ;
        end
      end
      default: begin
        state_next = ppmds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppmds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_gap <= ppmds_pkg::SYNC_GAP_RESET;
      pulse_min <= ppmds_pkg::PULSE_MIN_RESET;
      pulse_max <= ppmds_pkg::PULSE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppmds_pkg::REG_SYNC_GAP:  sync_gap <= cfg_data;
        ppmds_pkg::REG_PULSE_MIN: pulse_min <= cfg_data;
        ppmds_pkg::REG_PULSE_MAX: pulse_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge decode
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge <= 16'd0;
      frame_ch <= 4'd0;
      for (int i = 0; i < ppmds_pkg::CHANNELS; i++) begin
        pulse_store[i] <= ppmds_pkg::PULSE_RESET;
      end
    end else if (in_fire && in_ch.op == ppmds_pkg::OP_EDGE) begin
      last_edge <= in_ch.now_us;
      if (gap > sync_gap) begin
        frame_ch <= 4'd0;
      end else if (frame_ch < ppmds_pkg::FRAME_FULL) begin
        if (in_window) begin
          pulse_store[frame_ch[2:0]] <= gap;
        end
        frame_ch <= frame_ch + 4'd1;
      end
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_slot <= 2'd0;
      ch_idx <= 3'd0;
      step <= 2'd0;
    end else begin
      if (in_fire && in_ch.op == ppmds_pkg::OP_TICK) begin
        hist_slot <= hist_slot + 2'd1;
        ch_idx <= 3'd0;
        step <= 2'd0;
      end
      if (read_issue) begin
        step <= step + 2'd1;
      end
      if (upd_fire) begin
        ch_idx <= ch_idx + 3'd1;
        step <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (read_issue && step == hist_slot) begin
      hist_mem[rd_addr] <= cur_pulse;
    end
    if (read_issue) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppmds_pkg::HIST_ENTRIES; i++) begin
        hist_valid[i] <= 1'b0;
      end
    end else if (read_issue && step == hist_slot) begin
      hist_valid[rd_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (read_issue) begin
      rd_valid <= hist_valid[rd_addr];
      rd_use_pulse <= (step == hist_slot);
    end
    if (acc_clear) begin
      acc <= 18'd0;
    end else if (acc_add) begin
      acc <= acc + {2'b00, term};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppmds_pkg::CHANNELS; i++) begin
        smoothed[i] <= 16'd0;
      end
    end else if (upd_fire) begin
      smoothed[ch_idx] <= smoothed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_channel <= ch_idx;
      out_smoothed <= smoothed_next;
      out_last <= (ch_idx == ppmds_pkg::LAST_CHANNEL);
    end
  end

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.channel = out_channel;
  assign out_ch.smoothed_us = out_smoothed;
  assign out_ch.last = out_last;

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.op == ppmds_pkg::OP_TICK)
      |=> (state == ppmds_pkg::ST_READ && ch_idx == 3'd0 && step == 2'd0))
    else $error("tick did not start at channel zero");

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_ch <= ppmds_pkg::FRAME_FULL)
    else $error("frame channel counter passed the channel count");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_channel == ppmds_pkg::LAST_CHANNEL))
    else $error("last flag on a channel other than the final one");

  a_update_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ppmds_pkg::ST_UPDATE && out_valid && !out_ch.ready)
      |=> (state == ppmds_pkg::ST_UPDATE && $stable(ch_idx)))
    else $error("update advanced while the output register was full");

endmodule
